// ===== rtl/gbir_pkg.sv =====
// Shared types and constants of the pin bank interrupt register block.
package gbir_pkg;

	localparam int OFF_W      = 12;
	localparam int DATA_W     = 32;
	localparam int PIN_W      = 5;
	localparam int STATUS_W   = 18;
	localparam int FUNC_W     = 5;
	localparam int LEVEL_BIT  = 17;
	localparam int NUM_WORDS  = 4;
	localparam int NIB_W      = 4;
	localparam int NUM_PINS_DEF = 30;

	localparam logic [FUNC_W-1:0] FUNC_SW   = 5'd5;
	localparam logic [FUNC_W-1:0] FUNC_NONE = 5'd31;

	localparam logic [OFF_W-1:0] RAW_BASE = 12'h0F0;
	localparam logic [OFF_W-1:0] REG_LAST = 12'h15C;

	// register groups above the pin slots, 16 bytes each
	localparam logic [2:0] GRP_RAW   = 3'd0;
	localparam logic [2:0] GRP_EN0   = 3'd1;
	localparam logic [2:0] GRP_FRC0  = 3'd2;
	localparam logic [2:0] GRP_STAT0 = 3'd3;
	localparam logic [2:0] GRP_EN1   = 3'd4;
	localparam logic [2:0] GRP_FRC1  = 3'd5;
	localparam logic [2:0] GRP_STAT1 = 3'd6;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_PIN   = 2'd2
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} st_t;

	typedef struct packed {
		logic st_we;
		logic ct_we;
	} pin_wr_t;

endpackage

// ===== rtl/gbir_pin_store.sv =====
// Per-pin status and control memories with reset-valid bits.
module gbir_pin_store
	import gbir_pkg::*;
#(
	parameter int NUM_PINS = NUM_PINS_DEF,
	localparam int AW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	input  pin_wr_t             wr,
	input  logic [AW-1:0]       wr_addr,
	input  logic [STATUS_W-1:0] st_wdata,
	input  logic [DATA_W-1:0]   ct_wdata,
	output logic [STATUS_W-1:0] st_rdata,
	output logic [DATA_W-1:0]   ct_rdata
);

	logic [STATUS_W-1:0] st_mem [NUM_PINS];
	logic [DATA_W-1:0]   ct_mem [NUM_PINS];
	logic [NUM_PINS-1:0] st_vld_q;
	logic [NUM_PINS-1:0] ct_vld_q;
	logic [STATUS_W-1:0] st_rd_s1;
	logic [DATA_W-1:0]   ct_rd_s1;
	logic                st_vld_s1;
	logic                ct_vld_s1;

	always_ff @(posedge clk) begin
		if (wr.st_we) begin
			st_mem[wr_addr] <= st_wdata;
		end
		if (wr.ct_we) begin
			ct_mem[wr_addr] <= ct_wdata;
		end
		if (rd_en) begin
			st_rd_s1 <= st_mem[rd_addr];
			ct_rd_s1 <= ct_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q  <= '0;
			ct_vld_q  <= '0;
			st_vld_s1 <= 1'b0;
			ct_vld_s1 <= 1'b0;
		end else begin
			if (wr.st_we) begin
				st_vld_q[wr_addr] <= 1'b1;
			end
			if (wr.ct_we) begin
				ct_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				st_vld_s1 <= st_vld_q[rd_addr];
				ct_vld_s1 <= ct_vld_q[rd_addr];
			end
		end
	end

	// an entry never written reads as its reset value
	assign st_rdata = st_vld_s1 ? st_rd_s1 : STATUS_W'(FUNC_NONE);
	assign ct_rdata = ct_vld_s1 ? ct_rd_s1 : DATA_W'(FUNC_NONE);

endmodule

// ===== rtl/gpio_bank_interrupt_registers.sv =====
// Top level of the pin bank register block with edge and level interrupts.
// Each accepted word is a bus read, a bus write or a pin level change and
// yields exactly one result word: read data (zero for anything but a read),
// both processor interrupt lines as they stand after the word, and a flag
// for a bus access that hit no register or wrote an interrupt status word.
// The per-pin status and control words live in synchronous memories; the
// accept edge launches the memory read, and the write-back state then
// modifies the entry, writes it back and loads the result register. A new
// word is taken as soon as the previous one has been written back; a result
// left waiting holds the block in its write-back cycle. Memory entries come
// out of reset through valid bits, so no clearing pass is needed.
module gpio_bank_interrupt_registers
	import gbir_pkg::*;
#(
	parameter int NUM_PINS = NUM_PINS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [OFF_W-1:0]  offset,
	input  logic [DATA_W-1:0] write_data,
	input  logic [PIN_W-1:0]  pin,
	input  logic              level,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] read_data,
	output logic              irq_proc0,
	output logic              irq_proc1,
	output logic              bad_offset
);

	localparam int AW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
	localparam int SEL_W = OFF_W - 3;
	localparam logic [SEL_W-1:0] NP_SEL = SEL_W'(NUM_PINS);

	st_t state_q, state_d;

	// captured word
	op_t               op_q;
	logic [OFF_W-1:0]  off_q;
	logic [DATA_W-1:0] data_q;
	logic [PIN_W-1:0]  pin_q;
	logic              lvl_q;
	logic [AW-1:0]     addr_q;
	logic              in_range_q;

	// interrupt word registers
	logic [DATA_W-1:0] raw_q  [NUM_WORDS];
	logic [DATA_W-1:0] en0_q  [NUM_WORDS];
	logic [DATA_W-1:0] frc0_q [NUM_WORDS];
	logic [DATA_W-1:0] en1_q  [NUM_WORDS];
	logic [DATA_W-1:0] frc1_q [NUM_WORDS];
	logic [DATA_W-1:0] raw_d  [NUM_WORDS];
	logic [DATA_W-1:0] en0_d  [NUM_WORDS];
	logic [DATA_W-1:0] frc0_d [NUM_WORDS];
	logic [DATA_W-1:0] en1_d  [NUM_WORDS];
	logic [DATA_W-1:0] frc1_d [NUM_WORDS];

	// result register
	logic              out_valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic              irq0_q;
	logic              irq1_q;
	logic              bad_q;

	logic              accept;
	logic              exec_go;
	logic [SEL_W-1:0]  sel;
	logic              sel_in_range;
	pin_wr_t           pin_wr;
	logic [STATUS_W-1:0] st_cur;
	logic [DATA_W-1:0]   ct_cur;
	logic [STATUS_W-1:0] st_wdata;
	logic [DATA_W-1:0]   rd;
	logic                bad;
	logic [OFF_W-1:0]    grp_off;
	logic [2:0]          grp;
	logic [1:0]          idx;
	logic [NIB_W-1:0]    mask;
	logic [NIB_W-1:0]    hit;
	logic                old_lvl;
	logic [NUM_PINS-1:0] pend0;
	logic [NUM_PINS-1:0] pend1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		exec_go  = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: exec_go  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	// slot number: from the offset for bus words, from the pin field otherwise
	assign sel = (operation == OP_PIN) ? SEL_W'(pin) : offset[OFF_W-1:3];
	assign sel_in_range = sel < NP_SEL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the word for its write-back cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_t'(operation);
			off_q      <= offset;
			data_q     <= write_data;
			pin_q      <= pin;
			lvl_q      <= level;
			addr_q     <= sel[AW-1:0];
			in_range_q <= sel_in_range;
		end
	end

	gbir_pin_store #(
		.NUM_PINS (NUM_PINS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (sel[AW-1:0]),
		.wr       (pin_wr),
		.wr_addr  (addr_q),
		.st_wdata (st_wdata),
		.ct_wdata (data_q),
		.st_rdata (st_cur),
		.ct_rdata (ct_cur)
	);

	assign grp_off = off_q - RAW_BASE;
	assign grp     = grp_off[6:4];
	assign idx     = off_q[3:2];
	assign mask    = ct_cur[DATA_W-1 -: NIB_W];
	assign old_lvl = st_cur[LEVEL_BIT];

	// latch conditions: level low, level high, falling edge, rising edge
	assign hit = {mask[3] && !old_lvl && lvl_q,
		mask[2] && old_lvl && !lvl_q,
		mask[1] && lvl_q,
		mask[0] && !lvl_q};

	// modify: decode the word against the register map
	always_comb begin
		rd       = '0;
		bad      = 1'b0;
		pin_wr   = '0;
		st_wdata = st_cur;
		raw_d    = raw_q;
		en0_d    = en0_q;
		frc0_d   = frc0_q;
		en1_d    = en1_q;
		frc1_d   = frc1_q;
		case (op_q)
			OP_READ, OP_WRITE: begin
				if (off_q < RAW_BASE) begin
					if (!in_range_q) begin
						bad = 1'b1;
					end else if (off_q[2:0] == 3'd0) begin
						// status is read only; writes drop silently
						if (op_q == OP_READ) begin
							rd = DATA_W'(st_cur);
						end
					end else if (op_q == OP_WRITE) begin
						pin_wr.ct_we = exec_go;
						if (data_q[FUNC_W-1:0] == FUNC_SW) begin
							pin_wr.st_we = exec_go;
							st_wdata = {st_cur[STATUS_W-1:FUNC_W], FUNC_SW};
						end
					end else begin
						rd = ct_cur;
					end
				end else if (off_q[1:0] != 2'd0 || off_q > REG_LAST) begin
					bad = 1'b1;
				end else begin
					case (grp)
						GRP_RAW: begin
							if (op_q == OP_WRITE) begin
								raw_d[idx] = raw_q[idx] & ~data_q;
							end else begin
								rd = raw_q[idx];
							end
						end
						GRP_EN0: begin
							if (op_q == OP_WRITE) begin
								en0_d[idx] = data_q;
							end else begin
								rd = en0_q[idx];
							end
						end
						GRP_FRC0: begin
							if (op_q == OP_WRITE) begin
								frc0_d[idx] = data_q;
							end else begin
								rd = frc0_q[idx];
							end
						end
						GRP_STAT0: begin
							if (op_q == OP_WRITE) begin
								bad = 1'b1;
							end else begin
								rd = raw_q[idx] & en0_q[idx];
							end
						end
						GRP_EN1: begin
							if (op_q == OP_WRITE) begin
								en1_d[idx] = data_q;
							end else begin
								rd = en1_q[idx];
							end
						end
						GRP_FRC1: begin
							if (op_q == OP_WRITE) begin
								frc1_d[idx] = data_q;
							end else begin
								rd = frc1_q[idx];
							end
						end
						GRP_STAT1: begin
							if (op_q == OP_WRITE) begin
								bad = 1'b1;
							end else begin
								rd = raw_q[idx] & en1_q[idx];
							end
						end
						default: bad = 1'b1;
					endcase
				end
			end
			OP_PIN: begin
				if (in_range_q) begin
					pin_wr.st_we = exec_go;
					st_wdata[LEVEL_BIT] = lvl_q;
					// only a pin under software control latches interrupts
					if (ct_cur[FUNC_W-1:0] == FUNC_SW) begin
						raw_d[pin_q[4:3]] = raw_q[pin_q[4:3]] |
							(DATA_W'(hit) << {pin_q[2:0], 2'b00});
					end
				end
			end
			default: ;
		endcase
	end

	// per-pin pending terms on the updated words, then one OR per processor
	for (genvar g = 0; g < NUM_PINS; g++) begin : g_pend
		localparam int W = g / 8;
		localparam int N = (g % 8) * NIB_W;
		assign pend0[g] = (|raw_d[W][N +: NIB_W]) && (|en0_d[W][N +: NIB_W]);
		assign pend1[g] = (|raw_d[W][N +: NIB_W]) && (|en1_d[W][N +: NIB_W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_WORDS; k++) begin
				raw_q[k]  <= '0;
				en0_q[k]  <= '0;
				frc0_q[k] <= '0;
				en1_q[k]  <= '0;
				frc1_q[k] <= '0;
			end
		end else if (exec_go) begin
			raw_q  <= raw_d;
			en0_q  <= en0_d;
			frc0_q <= frc0_d;
			en1_q  <= en1_d;
			frc1_q <= frc1_d;
		end
	end

	// result register: load on write-back, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			rdata_q <= rd;
			irq0_q  <= |pend0;
			irq1_q  <= |pend1;
			bad_q   <= bad;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = rdata_q;
	assign irq_proc0  = irq0_q;
	assign irq_proc1  = irq1_q;
	assign bad_offset = bad_q;

`ifndef NO_ASSERTIONS
	a_rise_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result appeared without a write-back cycle");

	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(bad_q && rdata_q != '0))
		else $error("flagged access returned nonzero data");

	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && op_q != OP_READ) |=> rdata_q == '0)
		else $error("non-read word returned data");

	a_mem_write_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(pin_wr.st_we || pin_wr.ct_we) |-> (state_q == ST_EXEC && in_range_q))
		else $error("pin memory written outside write-back");

	a_result_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(rdata_q)))
		else $error("waiting result dropped or changed");
`endif

endmodule
